@@ sv/spq_pkg.sv @@
// spq_pkg: shared sizes, operation codes, cell commands and control types
// for the sorted priority queue; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

   localparam int DEPTH = 16;
   localparam int KEY_W = 34;
   localparam int PAY_W = 32;
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   typedef enum logic [1:0] {
      FUNC_ENQ  = 2'd0,
      FUNC_DEQ  = 2'd1,
      FUNC_PEEK = 2'd2,
      FUNC_LIST = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // what every cell does in a cycle
   typedef enum logic [1:0] {
      CMD_HOLD = 2'd0,
      CMD_ENQ  = 2'd1,
      CMD_DEQ  = 2'd2,
      CMD_ROT  = 2'd3
   } cmd_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_LIST = 1'b1
   } state_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [KEY_W-1:0]  key;
      logic [PAY_W-1:0]  payload;
   } cell_ctrl_type;

endpackage

`default_nettype wire

@@ sv/spq_cell.sv @@
// spq_cell: one slot of the sorted chain, holding a key and payload tag
// depends on spq_pkg
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
   input  wire logic                       clock,
   input  wire spq_pkg::cell_ctrl_type     ctrl,
   input  wire logic                       first,
   input  wire logic                       valid,
   input  wire logic                       wrap,
   input  wire logic                       left_ins,
   input  wire logic [spq_pkg::KEY_W-1:0]  left_key,
   input  wire logic [spq_pkg::PAY_W-1:0]  left_payload,
   input  wire logic [spq_pkg::KEY_W-1:0]  right_key,
   input  wire logic [spq_pkg::PAY_W-1:0]  right_payload,
   input  wire logic [spq_pkg::KEY_W-1:0]  head_key,
   input  wire logic [spq_pkg::PAY_W-1:0]  head_payload,
   output logic                            ins,
   output logic [spq_pkg::KEY_W-1:0]       key,
   output logic [spq_pkg::PAY_W-1:0]       payload
);

   logic [spq_pkg::KEY_W-1:0] key_ff, key_in;
   logic [spq_pkg::PAY_W-1:0] payload_ff, payload_in;

   // new entry lands here or before; head slot takes only a strictly smaller key
   always_comb begin
      if (first) begin
         ins = !valid || (ctrl.key < key_ff);
      end else begin
         ins = !valid || (key_ff >= ctrl.key);
      end
   end

   always_comb begin
      key_in     = key_ff;
      payload_in = payload_ff;
      case (ctrl.cmd)
         spq_pkg::CMD_ENQ: begin
            if (left_ins) begin
               key_in     = left_key;
               payload_in = left_payload;
            end else if (ins) begin
               key_in     = ctrl.key;
               payload_in = ctrl.payload;
            end
         end
         spq_pkg::CMD_DEQ: begin
            key_in     = right_key;
            payload_in = right_payload;
         end
         spq_pkg::CMD_ROT: begin
            if (wrap) begin
               key_in     = head_key;
               payload_in = head_payload;
            end else begin
               key_in     = right_key;
               payload_in = right_payload;
            end
         end
         default: begin
            key_in     = key_ff;
            payload_in = payload_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

   assign key     = key_ff;
   assign payload = payload_ff;

endmodule

`default_nettype wire

@@ sv/sorted_priority_queue.sv @@
// sorted_priority_queue: top level, control and a row of spq_cell slots
// depends on spq_pkg and spq_cell
`timescale 1ns / 1ps
`default_nettype none

// Min-first priority queue of up to spq_pkg::DEPTH entries kept sorted in a
// row of cells, smallest key in cell 0.
// req channel: req_func selects enqueue, dequeue, peek or list; req_key and
// req_payload matter for enqueue only. rsp channel: one transfer per
// enqueue, dequeue or peek, and one per held entry for a list (one transfer
// if empty), with rsp_last on the final transfer of each request.
// Enqueue, dequeue and peek are handled in the accepting cycle: the whole row
// shifts or inserts at once, and the result sits in the output register the next
// cycle, so one request per cycle is sustained while the receiver keeps up.
// For a list of n entries the accepting cycle only arms the walk; then, at each
// step, the row rotates by one slot and the head goes out, one step per cycle
// while the output register is free, and the first entry comes from the first
// step, not from the accepting cycle; after n steps the order is as before.
// req_ready is low during the n steps. The output register is a single stage;
// a request or list step is taken only when it is empty or being drained in
// the same cycle, so a stalled receiver stalls the request side with nothing lost.
// Reset (synchronous, active high) empties the queue and the output
// register; the cell contents need no clearing as only held ones are read.

module sorted_priority_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [1:0]                 req_func,
   input  wire logic [spq_pkg::KEY_W-1:0]  req_key,
   input  wire logic [spq_pkg::PAY_W-1:0]  req_payload,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_entry_valid,
   output logic [spq_pkg::KEY_W-1:0]       rsp_key_out,
   output logic [spq_pkg::PAY_W-1:0]       rsp_payload_out,
   output logic                            rsp_last
);

   localparam int N = spq_pkg::DEPTH;
   localparam int CW = spq_pkg::CNT_W;

   spq_pkg::state_type     state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          rem_ff, rem_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [1:0]                   status_ff, status_in;
   logic                         entry_valid_ff, entry_valid_in;
   logic [spq_pkg::KEY_W-1:0]    key_out_ff, key_out_in;
   logic [spq_pkg::PAY_W-1:0]    payload_out_ff, payload_out_in;
   logic                         last_ff, last_in;

   spq_pkg::cell_ctrl_type ctrl;
   spq_pkg::func_type      func;

   logic out_free;
   logic req_fire;
   logic empty;
   logic full;
   logic list_step;

   logic [N-1:0]                 cell_ins;
   logic [spq_pkg::KEY_W-1:0]    cell_key [N];
   logic [spq_pkg::PAY_W-1:0]    cell_pay [N];

   assign func      = spq_pkg::func_type'(req_func);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == spq_pkg::ST_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;
   assign empty     = (count_ff == '0);
   assign full      = (count_ff == spq_pkg::DEPTH_CNT);
   assign list_step = (state_ff == spq_pkg::ST_LIST) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spq_pkg::ST_IDLE: begin
            if (req_fire && func == spq_pkg::FUNC_LIST && !empty) begin
               state_in = spq_pkg::ST_LIST;
            end
         end
         spq_pkg::ST_LIST: begin
            if (out_free && rem_ff == CW'(1)) begin
               state_in = spq_pkg::ST_IDLE;
            end
         end
         default: state_in = spq_pkg::ST_IDLE;
      endcase
   end

   // outputs: cell command, counters and result register
   always_comb begin
      ctrl.cmd       = spq_pkg::CMD_HOLD;
      ctrl.key       = req_key;
      ctrl.payload   = req_payload;
      count_in       = count_ff;
      rem_in         = rem_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      status_in      = status_ff;
      entry_valid_in = entry_valid_ff;
      key_out_in     = key_out_ff;
      payload_out_in = payload_out_ff;
      last_in        = last_ff;
      case (state_ff)
         spq_pkg::ST_IDLE: begin
            if (req_fire) begin
               rsp_valid_in   = 1'b1;
               status_in      = spq_pkg::STATUS_OK;
               entry_valid_in = 1'b0;
               key_out_in     = '0;
               payload_out_in = '0;
               last_in        = 1'b1;
               case (func)
                  spq_pkg::FUNC_ENQ: begin
                     if (full) begin
                        status_in = spq_pkg::STATUS_FULL;
                     end else begin
                        ctrl.cmd = spq_pkg::CMD_ENQ;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  spq_pkg::FUNC_DEQ: begin
                     if (empty) begin
                        status_in = spq_pkg::STATUS_EMPTY;
                     end else begin
                        ctrl.cmd       = spq_pkg::CMD_DEQ;
                        count_in       = count_ff - CW'(1);
                        entry_valid_in = 1'b1;
                        key_out_in     = cell_key[0];
                        payload_out_in = cell_pay[0];
                     end
                  end
                  spq_pkg::FUNC_PEEK: begin
                     if (empty) begin
                        status_in = spq_pkg::STATUS_EMPTY;
                     end else begin
                        entry_valid_in = 1'b1;
                        key_out_in     = cell_key[0];
                        payload_out_in = cell_pay[0];
                     end
                  end
                  default: begin
                     // list: empty answers at once, else the walk starts next cycle
                     if (empty) begin
                        status_in = spq_pkg::STATUS_EMPTY;
                     end else begin
                        rsp_valid_in = rsp_valid_ff && !rsp_ready;
                        status_in    = status_ff;
                        last_in      = last_ff;
                        key_out_in   = key_out_ff;
                        payload_out_in = payload_out_ff;
                        entry_valid_in = entry_valid_ff;
                        rem_in       = count_ff;
                     end
                  end
               endcase
            end
         end
         spq_pkg::ST_LIST: begin
            if (list_step) begin
               ctrl.cmd       = spq_pkg::CMD_ROT;
               rsp_valid_in   = 1'b1;
               status_in      = spq_pkg::STATUS_OK;
               entry_valid_in = 1'b1;
               key_out_in     = cell_key[0];
               payload_out_in = cell_pay[0];
               last_in        = (rem_ff == CW'(1));
               rem_in         = rem_ff - CW'(1);
            end
         end
         default: begin
            ctrl.cmd = spq_pkg::CMD_HOLD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spq_pkg::ST_IDLE;
         count_ff     <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff      <= status_in;
      entry_valid_ff <= entry_valid_in;
      key_out_ff     <= key_out_in;
      payload_out_ff <= payload_out_in;
      last_ff        <= last_in;
   end

   // row of cells, cell 0 is the head
   for (genvar i = 0; i < N; i++) begin : g_cell
      logic                         left_ins;
      logic [spq_pkg::KEY_W-1:0]    left_key;
      logic [spq_pkg::PAY_W-1:0]    left_pay;
      logic [spq_pkg::KEY_W-1:0]    right_key;
      logic [spq_pkg::PAY_W-1:0]    right_pay;

      if (i == 0) begin : g_head
         assign left_ins = 1'b0;
         assign left_key = cell_key[0];
         assign left_pay = cell_pay[0];
      end else begin : g_mid
         assign left_ins = cell_ins[i-1];
         assign left_key = cell_key[i-1];
         assign left_pay = cell_pay[i-1];
      end

      if (i == N - 1) begin : g_tail
         assign right_key = cell_key[i];
         assign right_pay = cell_pay[i];
      end else begin : g_inner
         assign right_key = cell_key[i+1];
         assign right_pay = cell_pay[i+1];
      end

      spq_cell u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .first         (i == 0),
         .valid         (CW'(i) < count_ff),
         .wrap          (CW'(i) == count_ff - CW'(1)),
         .left_ins      (left_ins),
         .left_key      (left_key),
         .left_payload  (left_pay),
         .right_key     (right_key),
         .right_payload (right_pay),
         .head_key      (cell_key[0]),
         .head_payload  (cell_pay[0]),
         .ins           (cell_ins[i]),
         .key           (cell_key[i]),
         .payload       (cell_pay[i])
      );
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_valid = entry_valid_ff;
   assign rsp_key_out     = key_out_ff;
   assign rsp_payload_out = payload_out_ff;
   assign rsp_last        = last_ff;

   // occupancy never passes the row length
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= spq_pkg::DEPTH_CNT)
      else $error("occupancy beyond depth");

   // a list walk always has entries left to send, no more than held
   assert property (@(posedge clock) disable iff (reset)
      state_ff == spq_pkg::ST_LIST |-> (rem_ff != '0 && rem_ff <= count_ff))
      else $error("list counter out of range");

   // the final list step returns to idle and flags last
   assert property (@(posedge clock) disable iff (reset)
      (list_step && rem_ff == CW'(1)) |=>
         (state_ff == spq_pkg::ST_IDLE && rsp_valid && rsp_last))
      else $error("list did not close with last");

   // the occupancy holds still during a list walk
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == spq_pkg::ST_LIST && $past(state_ff) == spq_pkg::ST_LIST)
         |-> $stable(count_ff))
      else $error("occupancy changed during list");

endmodule

`default_nettype wire
